FILE: hdl/sbbf_pkg.sv
`timescale 1ns / 1ps

package sbbf_pkg;

  localparam int MAX_BLOCKS      = 4096;
  localparam int WORDS_PER_BLOCK = 8;
  localparam int WORD_W          = 32;
  localparam int ROW_W           = WORD_W * WORDS_PER_BLOCK;
  localparam int HASH_W          = 64;
  localparam int KEY_W           = 32;
  localparam int CFG_W           = 13;
  localparam int BIT_SEL_W       = 5;
  localparam int BLK_AW          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BLK_CW          = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W          = KEY_W + BLK_CW;

  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = CFG_W'(4096);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TEST   = 1'b1;

  typedef logic [BLK_AW-1:0] blk_addr_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef struct packed {
    logic      opcode;
    blk_addr_t block;
    row_t      masks;
  } probe_t;

  function automatic logic [WORD_W-1:0] salt(input int unsigned idx);
    logic [WORD_W-1:0] s;
    begin
      case (idx)
        0:       s = 32'h47b6137b;
        1:       s = 32'h44974d91;
        2:       s = 32'h8824ad5b;
        3:       s = 32'ha2b7289d;
        4:       s = 32'h705495c7;
        5:       s = 32'h2df1424b;
        6:       s = 32'h9efc4947;
        default: s = 32'h5c6bfb31;
      endcase
      return s;
    end
  endfunction

endpackage

FILE: hdl/sbbf_if.sv
`timescale 1ns / 1ps

interface sbbf_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [sbbf_pkg::HASH_W-1:0] hash_value;

  modport source (output valid, output opcode, output hash_value, input ready);
  modport sink   (input valid, input opcode, input hash_value, output ready);
endinterface

interface sbbf_rsp_if;
  logic valid;
  logic ready;
  logic maybe_present;

  modport source (output valid, output maybe_present, input ready);
  modport sink   (input valid, input maybe_present, output ready);
endinterface

interface sbbf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sbbf_pkg::CFG_W-1:0] block_count;

  modport source (output valid, output block_count, input ready);
  modport sink   (input valid, input block_count, output ready);
endinterface

FILE: hdl/split_block_bloom_filter_top.sv
`timescale 1ns / 1ps

// Split-block Bloom filter, 256-bit blocks, up to 4096 blocks in one RAM row
// per block. Each request passes a hash/mask stage, a RAM read, then check
// and write-back of the same row, one request at a time; the check waits
// while an earlier result is unread. The result sits in an output register,
// so the next request is taken while it waits. After reset the RAM is swept
// to zero, one row per cycle, over all 4096 rows; no request is accepted
// during the sweep, while block_count writes are taken at any time.

module split_block_bloom_filter_top (
  input  logic       clk,
  input  logic       rst_n,
  sbbf_req_if.sink   in_req,
  sbbf_rsp_if.source out_rsp,
  sbbf_cfg_if.sink   cfg_wr
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  sbbf_pkg::blk_addr_t          clr_cnt_r, clr_cnt_nxt;
  logic [sbbf_pkg::CFG_W-1:0]   block_count_r, block_count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic [sbbf_pkg::BLK_CW-1:0]  n_eff;
  sbbf_pkg::probe_t             probe_r;
  logic                         accept;
  logic                         out_free;
  logic                         hit;
  logic                         ram_we;
  logic                         ram_re;
  sbbf_pkg::blk_addr_t          ram_waddr;
  sbbf_pkg::row_t               ram_wdata;
  sbbf_pkg::row_t               ram_rdata;

  assign in_req.ready  = (state_r == ST_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.maybe_present = out_hit_r;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    if (block_count_r == '0) begin
      n_eff = sbbf_pkg::BLK_CW'(1);
    end else if (32'(block_count_r) > 32'(sbbf_pkg::MAX_BLOCKS)) begin
      n_eff = sbbf_pkg::BLK_CW'(sbbf_pkg::MAX_BLOCKS);
    end else begin
      n_eff = sbbf_pkg::BLK_CW'(block_count_r);
    end
  end

  sbbf_hash u_hash (
    .clk        (clk),
    .en         (accept),
    .opcode     (in_req.opcode),
    .hash_value (in_req.hash_value),
    .n_eff      (n_eff),
    .probe_r    (probe_r)
  );

  sbbf_ram #(
    .WIDTH (sbbf_pkg::ROW_W),
    .DEPTH (sbbf_pkg::MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (probe_r.block),
    .rdata (ram_rdata)
  );

  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BLOCK; i++) begin
      if ((ram_rdata[i*sbbf_pkg::WORD_W +: sbbf_pkg::WORD_W] &
           probe_r.masks[i*sbbf_pkg::WORD_W +: sbbf_pkg::WORD_W]) == '0) begin
        hit = 1'b0;
      end
    end
  end

  assign ram_re = (state_r == ST_READ);

  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    block_count_nxt = block_count_r;
    out_valid_nxt   = out_valid_r;
    out_hit_nxt     = out_hit_r;
    ram_we          = 1'b0;
    ram_waddr       = probe_r.block;
    ram_wdata       = ram_rdata | probe_r.masks;

    if (cfg_wr.valid) begin
      block_count_nxt = cfg_wr.block_count;
    end
    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == sbbf_pkg::blk_addr_t'(sbbf_pkg::MAX_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ram_we        = (probe_r.opcode == sbbf_pkg::OP_INSERT);
          out_valid_nxt = 1'b1;
          out_hit_nxt   = (probe_r.opcode == sbbf_pkg::OP_TEST) && hit;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      block_count_r <= sbbf_pkg::BLOCK_COUNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      block_count_r <= block_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
  end

endmodule

FILE: hdl/sbbf_ram.sv
`timescale 1ns / 1ps

module sbbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sbbf_hash.sv
`timescale 1ns / 1ps

module sbbf_hash (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         opcode,
  input  logic [sbbf_pkg::HASH_W-1:0]  hash_value,
  input  logic [sbbf_pkg::BLK_CW-1:0]  n_eff,
  output sbbf_pkg::probe_t             probe_r
);

  logic [sbbf_pkg::KEY_W-1:0]  upper;
  logic [sbbf_pkg::KEY_W-1:0]  key;
  logic [sbbf_pkg::PROD_W-1:0] blk_prod;
  sbbf_pkg::probe_t            probe_nxt;

  assign upper = hash_value[sbbf_pkg::HASH_W-1 -: sbbf_pkg::KEY_W];
  assign key   = hash_value[sbbf_pkg::KEY_W-1:0];

  always_comb begin
    logic [sbbf_pkg::WORD_W-1:0]    prod;
    logic [sbbf_pkg::BIT_SEL_W-1:0] bsel;
    blk_prod = sbbf_pkg::PROD_W'(upper) * sbbf_pkg::PROD_W'(n_eff);
    probe_nxt.opcode = opcode;
    probe_nxt.block  = blk_prod[sbbf_pkg::KEY_W +: sbbf_pkg::BLK_AW];
    probe_nxt.masks  = '0;
    for (int i = 0; i < sbbf_pkg::WORDS_PER_BLOCK; i++) begin
      prod = key * sbbf_pkg::salt(i);
      bsel = prod[sbbf_pkg::WORD_W-1 -: sbbf_pkg::BIT_SEL_W];
      probe_nxt.masks[i*sbbf_pkg::WORD_W + int'(bsel)] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      probe_r <= probe_nxt;
    end
  end

endmodule
